// File: src/tcch_pkg.sv
`timescale 1ns / 1ps
package tcch_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SCALE_FRAC   = 12;

   localparam int CW       = 34;
   localparam int ITER_W   = $clog2(CORDIC_STEPS);
   localparam int RSUM_W   = 18;
   localparam int SCALE_W  = RSUM_W + SCALE_FRAC;
   localparam int MUL_A_W  = 35;
   localparam int MUL_B_W  = SCALE_W + 1;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int DIV_BITS = 2;
   localparam int DIV_W0   = (SCALE_W > 30) ? SCALE_W : 30;
   localparam int DIV_W    = DIV_W0 + (DIV_W0 % 2);
   localparam int DVS_W    = 18;
   localparam int SMOOTH_DIV = 10;

   localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
   localparam logic signed [CW-1:0] HALF_TURN   = CW'(1179648000);

   typedef struct packed {
      logic               mode;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
      logic signed [15:0] tilt_about_x;
      logic signed [15:0] tilt_about_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] corrected_x;
      logic signed [15:0] corrected_y;
      logic signed [15:0] corrected_z;
      logic [15:0]        heading;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic vectoring;
   } cordic_cmd_type;

   function automatic logic signed [CW-1:0] atan_entry(input int idx);
      logic signed [CW-1:0] v;
      case (idx)
         0:  v = CW'(294912000);
         1:  v = CW'(174096719);
         2:  v = CW'(91987925);
         3:  v = CW'(46694507);
         4:  v = CW'(23437865);
         5:  v = CW'(11730358);
         6:  v = CW'(5866610);
         7:  v = CW'(2933484);
         8:  v = CW'(1466765);
         9:  v = CW'(733385);
         10: v = CW'(366693);
         11: v = CW'(183347);
         12: v = CW'(91674);
         13: v = CW'(45837);
         14: v = CW'(22918);
         15: v = CW'(11459);
         16: v = CW'(5730);
         17: v = CW'(2865);
         18: v = CW'(1432);
         19: v = CW'(716);
         20: v = CW'(358);
         21: v = CW'(179);
         22: v = CW'(90);
         23: v = CW'(45);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// File: src/tilt_compensated_compass_heading_top.sv
`timescale 1ns / 1ps
// Tilt-compensated compass with hard- and soft-iron correction.
// Request channel (req_valid/req_stall/req_data): one magnetometer sample
// with roll and pitch. A calibration request (mode 0) is absorbed in the
// cycle it is accepted and gives no response. A measurement request
// (mode 1) gives one response (rsp_valid/rsp_stall/rsp_data) with the
// corrected axes and the heading in hundredths of a degree.
// A measurement uses three scale divisions and two smoothing divisions on
// a shared radix-4 divider, up to three CORDIC runs of 16 iterations on
// one shared CORDIC unit (the heading run is skipped when the smoothed y
// is zero), and ten products on one shared multiplier. A zero-range axis
// skips its division. req_stall is high while a measurement is in work;
// one calibration request per cycle is taken while the block is idle.
// The response sits in an output register; a stalled response holds and
// the block still accepts the next request, finishing it only once the
// register is free. csr_write_enable writes the declination.
// Reset (synchronous) empties the output, clears calibration and the
// smoothing filter, and sets the declination to 9.30 degrees.
module tilt_compensated_compass_heading_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tcch_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tcch_pkg::rsp_type  rsp_data,
   input  logic               csr_write_enable,
   input  logic signed [15:0] csr_write_data
);
   import tcch_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_SCALE   = 14'b00000000000010,
      S_SDIV    = 14'b00000000000100,
      S_CMUL    = 14'b00000000001000,
      S_CSAT    = 14'b00000000010000,
      S_TSTART  = 14'b00000000100000,
      S_TWAIT   = 14'b00000001000000,
      S_TMUL    = 14'b00000010000000,
      S_TACC    = 14'b00000100000000,
      S_SMSTART = 14'b00001000000000,
      S_SMWAIT  = 14'b00010000000000,
      S_ASTART  = 14'b00100000000000,
      S_AWAIT   = 14'b01000000000000,
      S_HEAD    = 14'b10000000000000
   } state_type;

   typedef enum logic [2:0] {
      T_YC  = 3'd0,
      T_YS  = 3'd1,
      T_XS  = 3'd2,
      T_XSS = 3'd3,
      T_ZS  = 3'd4,
      T_ZSC = 3'd5,
      T_XC  = 3'd6
   } tilt_step_type;

   localparam int ACCX_W = 49;
   localparam int ACCY_W = 37;

   localparam logic signed [17:0] A_HALF_P = 18'sd18000;
   localparam logic signed [17:0] A_HALF_N = -18'sd18000;
   localparam logic signed [17:0] A_FULL   = 18'sd36000;
   localparam logic signed [17:0] A_QUAR_P = 18'sd9000;
   localparam logic signed [17:0] A_QUAR_N = -18'sd9000;
   localparam logic signed [17:0] ANG_HALF = 18'sd18000;
   localparam logic signed [19:0] TURN_H   = 20'sd36000;
   localparam logic signed [CW-1:0] RND15  = CW'(16384);
   localparam logic signed [CW-1:0] RND16  = CW'(32768);
   localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
   localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-32768);
   localparam logic signed [DIV_W:0] SM_HI = (DIV_W+1)'((1 << 24) - 1);
   localparam logic signed [DIV_W:0] SM_LO = (DIV_W+1)'(-(1 << 24));

   state_type     state_ff, state_in;
   tilt_step_type step_ff, step_in;
   logic [1:0]    ax_ff, ax_in;
   logic          calib_ff, calib_in;
   logic signed [15:0] decl_ff, decl_in;
   logic signed [15:0] min_ff [3];
   logic signed [15:0] min_in [3];
   logic signed [15:0] max_ff [3];
   logic signed [15:0] max_in [3];
   logic signed [15:0] cor_ff [3];
   logic signed [15:0] cor_in [3];
   logic signed [17:0] sin_ff [2];
   logic signed [17:0] sin_in [2];
   logic signed [17:0] cos_ff [2];
   logic signed [17:0] cos_in [2];
   logic signed [24:0] sm_ff [2];
   logic signed [24:0] sm_in [2];
   req_type       req_ff, req_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [MUL_A_W-1:0] tmp_ff, tmp_in;
   logic signed [ACCX_W-1:0] accx_ff, accx_in;
   logic signed [ACCY_W-1:0] accy_ff, accy_in;
   logic          neg_ff, neg_in;
   logic signed [17:0] ang_ff, ang_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic signed [15:0] in_raw [3];
   logic signed [15:0] ms_raw [3];
   logic [16:0]        rng [3];
   logic [RSUM_W-1:0]  rsum;
   logic [16:0]        rng_sel;
   logic signed [16:0] osum, offv;
   logic signed [17:0] d_sel;
   logic signed [PROD_W-1:0] pr_rnd, pr_sh;
   logic signed [15:0] sat_val;
   logic signed [17:0] a0, a1, a2;
   logic               tneg;
   logic signed [CW-1:0] tz0, xr, yr;
   logic signed [17:0] cos_val, sin_val;
   logic signed [29:0] tx, ty, tsel;
   logic signed [31:0] num;
   logic signed [DIV_W:0] qv, sq;
   logic signed [24:0] sm_val;
   logic signed [19:0] h0, h1, h2;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_dividend, div_q;
   logic [DVS_W-1:0]   div_divisor;
   cordic_cmd_type     ccmd;
   logic signed [CW-1:0] cx0, cy0, cz0, cor_x, cor_y, cor_z;
   logic               cor_done;

   tcch_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   tcch_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .cmd   (ccmd),
      .x0    (cx0),
      .y0    (cy0),
      .z0    (cz0),
      .done  (cor_done),
      .x     (cor_x),
      .y     (cor_y),
      .z     (cor_z)
   );

   assign mul_p = mul_a * mul_b;

   assign in_raw[0] = req_data.raw_x;
   assign in_raw[1] = req_data.raw_y;
   assign in_raw[2] = req_data.raw_z;
   assign ms_raw[0] = req_ff.raw_x;
   assign ms_raw[1] = req_ff.raw_y;
   assign ms_raw[2] = req_ff.raw_z;

   // hard-iron offset and range per axis
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rng[k] = 17'({max_ff[k][15], max_ff[k]} - {min_ff[k][15], min_ff[k]});
      end
      rsum    = RSUM_W'(rng[0]) + RSUM_W'(rng[1]) + RSUM_W'(rng[2]);
      rng_sel = rng[ax_ff];
      osum    = {max_ff[ax_ff][15], max_ff[ax_ff]} + {min_ff[ax_ff][15], min_ff[ax_ff]};
      offv    = $signed(osum + 17'(osum[16])) >>> 1;
      d_sel   = 18'(ms_raw[ax_ff]) - 18'(offv);
      pr_rnd  = prod_ff + $signed({{(PROD_W-SCALE_FRAC){1'b0}}, {SCALE_FRAC{prod_ff[PROD_W-1]}}});
      pr_sh   = pr_rnd >>> SCALE_FRAC;
      if (pr_sh > SAT_HI) begin
         sat_val = 16'sh7FFF;
      end else if (pr_sh < SAT_LO) begin
         sat_val = -16'sh8000;
      end else begin
         sat_val = 16'(pr_sh);
      end
   end

   // tilt angle wrap and fold into +-90 degrees
   always_comb begin
      a0 = 18'(ax_ff[0] ? req_ff.tilt_about_y : req_ff.tilt_about_x);
      a1 = a0;
      if (a1 >= A_HALF_P) begin
         a1 = a1 - A_FULL;
      end
      if (a1 < A_HALF_N) begin
         a1 = a1 + A_FULL;
      end
      a2   = a1;
      tneg = 1'b0;
      if (a1 > A_QUAR_P) begin
         a2   = a1 - A_HALF_P;
         tneg = 1'b1;
      end else if (a1 < A_QUAR_N) begin
         a2   = a1 + A_HALF_P;
         tneg = 1'b1;
      end
      tz0     = CW'(a2) <<< 16;
      xr      = neg_ff ? -cor_x : cor_x;
      yr      = neg_ff ? -cor_y : cor_y;
      cos_val = 18'((xr + RND15) >>> 15);
      sin_val = 18'((yr + RND15) >>> 15);
   end

   // smoothing filter and heading wrap
   always_comb begin
      tx   = 30'(accx_ff >>> 23);
      ty   = 30'(accy_ff >>> 8);
      tsel = ax_ff[0] ? ty : tx;
      num  = (32'(sm_ff[ax_ff[0]]) <<< 3) - 32'(sm_ff[ax_ff[0]])
             + (32'(tsel) <<< 1) + 32'(tsel);
      qv   = $signed({1'b0, div_q});
      sq   = neg_ff ? -qv : qv;
      if (sq > SM_HI) begin
         sm_val = 25'(SM_HI);
      end else if (sq < SM_LO) begin
         sm_val = 25'(SM_LO);
      end else begin
         sm_val = 25'(sq);
      end
      h0 = 20'(ang_ff) + 20'(decl_ff);
      if (h0 < 0) begin
         h1 = h0 + TURN_H;
      end else if (h0 >= TURN_H) begin
         h1 = h0 - TURN_H;
      end else begin
         h1 = h0;
      end
      h2 = (h1 < 0) ? (h1 + TURN_H) : h1;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ax_in        = ax_ff;
      calib_in     = calib_ff;
      decl_in      = decl_ff;
      req_in       = req_ff;
      scale_in     = scale_ff;
      prod_in      = prod_ff;
      tmp_in       = tmp_ff;
      accx_in      = accx_ff;
      accy_in      = accy_ff;
      neg_in       = neg_ff;
      ang_in       = ang_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      for (int k = 0; k < 3; k++) begin
         min_in[k] = min_ff[k];
         max_in[k] = max_ff[k];
         cor_in[k] = cor_ff[k];
      end
      for (int k = 0; k < 2; k++) begin
         sin_in[k] = sin_ff[k];
         cos_in[k] = cos_ff[k];
         sm_in[k]  = sm_ff[k];
      end
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      ccmd         = '0;
      cx0          = '0;
      cy0          = '0;
      cz0          = '0;
      if (csr_write_enable) begin
         decl_in = csr_write_data;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (!req_data.mode) begin
                  calib_in = 1'b1;
                  for (int k = 0; k < 3; k++) begin
                     min_in[k] = calib_ff ? min_ff[k] : '0;
                     max_in[k] = calib_ff ? max_ff[k] : '0;
                     if (in_raw[k] < min_in[k]) begin
                        min_in[k] = in_raw[k];
                     end
                     if (in_raw[k] > max_in[k]) begin
                        max_in[k] = in_raw[k];
                     end
                  end
               end else begin
                  calib_in = 1'b0;
                  ax_in    = '0;
                  state_in = S_SCALE;
               end
            end
         end
         S_SCALE: begin
            if (rng_sel == '0) begin
               scale_in = SCALE_W'(1) << SCALE_FRAC;
               state_in = S_CMUL;
            end else begin
               div_start    = 1'b1;
               div_dividend = DIV_W'(rsum) << SCALE_FRAC;
               div_divisor  = DVS_W'(rng_sel) + DVS_W'({rng_sel, 1'b0});
               state_in     = S_SDIV;
            end
         end
         S_SDIV: begin
            if (div_done) begin
               scale_in = div_q[SCALE_W-1:0];
               state_in = S_CMUL;
            end
         end
         S_CMUL: begin
            mul_a    = MUL_A_W'(d_sel);
            mul_b    = $signed({1'b0, scale_ff});
            prod_in  = mul_p;
            state_in = S_CSAT;
         end
         S_CSAT: begin
            cor_in[ax_ff] = sat_val;
            if (ax_ff == 2'd2) begin
               ax_in    = '0;
               state_in = S_TSTART;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = S_SCALE;
            end
         end
         S_TSTART: begin
            ccmd.start     = 1'b1;
            ccmd.vectoring = 1'b0;
            cx0            = CORDIC_GAIN;
            cy0            = '0;
            cz0            = tz0;
            neg_in         = tneg;
            state_in       = S_TWAIT;
         end
         S_TWAIT: begin
            if (cor_done) begin
               cos_in[ax_ff[0]] = cos_val;
               sin_in[ax_ff[0]] = sin_val;
               if (ax_ff[0]) begin
                  ax_in    = '0;
                  step_in  = T_YC;
                  state_in = S_TMUL;
               end else begin
                  ax_in    = 2'd1;
                  state_in = S_TSTART;
               end
            end
         end
         S_TMUL: begin
            case (step_ff)
               T_YC: begin
                  mul_a = MUL_A_W'(cor_ff[1]);
                  mul_b = MUL_B_W'(cos_ff[0]);
               end
               T_YS: begin
                  mul_a = MUL_A_W'(cor_ff[2]);
                  mul_b = MUL_B_W'(sin_ff[0]);
               end
               T_XS: begin
                  mul_a = MUL_A_W'(cor_ff[1]);
                  mul_b = MUL_B_W'(sin_ff[0]);
               end
               T_XSS: begin
                  mul_a = tmp_ff;
                  mul_b = MUL_B_W'(sin_ff[1]);
               end
               T_ZS: begin
                  mul_a = MUL_A_W'(cor_ff[2]);
                  mul_b = MUL_B_W'(sin_ff[1]);
               end
               T_ZSC: begin
                  mul_a = tmp_ff;
                  mul_b = MUL_B_W'(cos_ff[0]);
               end
               T_XC: begin
                  mul_a = MUL_A_W'(cor_ff[0]);
                  mul_b = MUL_B_W'(cos_ff[1]);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
            prod_in  = mul_p;
            state_in = S_TACC;
         end
         S_TACC: begin
            step_in  = tilt_step_type'(step_ff + 3'd1);
            state_in = S_TMUL;
            case (step_ff)
               T_YC:  accy_in = ACCY_W'(prod_ff);
               T_YS:  accy_in = accy_ff - ACCY_W'(prod_ff);
               T_XS:  tmp_in  = MUL_A_W'(prod_ff);
               T_XSS: accx_in = ACCX_W'(prod_ff);
               T_ZS:  tmp_in  = MUL_A_W'(prod_ff);
               T_ZSC: accx_in = accx_ff + ACCX_W'(prod_ff);
               T_XC: begin
                  accx_in  = accx_ff + ACCX_W'(prod_ff <<< 15);
                  ax_in    = '0;
                  state_in = S_SMSTART;
               end
               default: state_in = S_SMSTART;
            endcase
         end
         S_SMSTART: begin
            div_start    = 1'b1;
            div_dividend = num[31] ? DIV_W'(-num + 32'sd9) : DIV_W'(num);
            div_divisor  = DVS_W'(SMOOTH_DIV);
            neg_in       = num[31];
            state_in     = S_SMWAIT;
         end
         S_SMWAIT: begin
            if (div_done) begin
               sm_in[ax_ff[0]] = sm_val;
               if (ax_ff[0]) begin
                  state_in = S_ASTART;
               end else begin
                  ax_in    = 2'd1;
                  state_in = S_SMSTART;
               end
            end
         end
         S_ASTART: begin
            if (sm_ff[1] == '0) begin
               ang_in   = sm_ff[0][24] ? ANG_HALF : '0;
               state_in = S_HEAD;
            end else begin
               ccmd.start     = 1'b1;
               ccmd.vectoring = 1'b1;
               cx0 = sm_ff[0][24] ? -CW'(sm_ff[0]) : CW'(sm_ff[0]);
               cy0 = sm_ff[0][24] ? -CW'(sm_ff[1]) : CW'(sm_ff[1]);
               cz0 = sm_ff[0][24] ? (sm_ff[1][24] ? -HALF_TURN : HALF_TURN) : '0;
               state_in = S_AWAIT;
            end
         end
         S_AWAIT: begin
            if (cor_done) begin
               ang_in   = 18'((cor_z + RND16) >>> 16);
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.corrected_x = cor_ff[0];
               rsp_in.corrected_y = cor_ff[1];
               rsp_in.corrected_z = cor_ff[2];
               rsp_in.heading     = 16'(h2);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= T_YC;
         ax_ff        <= '0;
         calib_ff     <= 1'b0;
         decl_ff      <= 16'sd930;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            min_ff[k] <= '0;
            max_ff[k] <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            sm_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ax_ff        <= ax_in;
         calib_ff     <= calib_in;
         decl_ff      <= decl_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            min_ff[k] <= min_in[k];
            max_ff[k] <= max_in[k];
         end
         for (int k = 0; k < 2; k++) begin
            sm_ff[k] <= sm_in[k];
         end
      end
      for (int k = 0; k < 3; k++) begin
         cor_ff[k] <= cor_in[k];
      end
      for (int k = 0; k < 2; k++) begin
         sin_ff[k] <= sin_in[k];
         cos_ff[k] <= cos_in[k];
      end
      req_ff   <= req_in;
      scale_ff <= scale_in;
      prod_ff  <= prod_in;
      tmp_ff   <= tmp_in;
      accx_ff  <= accx_in;
      accy_ff  <= accy_in;
      neg_ff   <= neg_in;
      ang_ff   <= ang_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: src/tcch_div.sv
`timescale 1ns / 1ps
module tcch_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tcch_pkg::DIV_W-1:0] dividend,
   input  logic [tcch_pkg::DVS_W-1:0] divisor,
   output logic                       done,
   output logic [tcch_pkg::DIV_W-1:0] quotient
);
   import tcch_pkg::*;

   localparam int CYCLES = DIV_W / DIV_BITS;
   localparam int CNT_W  = $clog2(CYCLES);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W:0]   rem_ff, rem_in, rem_t;
   logic [DIV_W-1:0] quo_ff, quo_in, quo_t;
   logic [DVS_W-1:0] dvs_ff, dvs_in;

   // restoring divide, DIV_BITS quotient bits per cycle
   always_comb begin
      rem_t = rem_ff;
      quo_t = quo_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         rem_t = {rem_t[DVS_W-1:0], quo_t[DIV_W-1]};
         quo_t = {quo_t[DIV_W-2:0], 1'b0};
         if (rem_t >= {1'b0, dvs_ff}) begin
            rem_t    = rem_t - {1'b0, dvs_ff};
            quo_t[0] = 1'b1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = rem_t;
         quo_in = quo_t;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/tcch_cordic.sv
`timescale 1ns / 1ps
module tcch_cordic (
   input  logic                           clock,
   input  logic                           reset,
   input  tcch_pkg::cordic_cmd_type       cmd,
   input  logic signed [tcch_pkg::CW-1:0] x0,
   input  logic signed [tcch_pkg::CW-1:0] y0,
   input  logic signed [tcch_pkg::CW-1:0] z0,
   output logic                           done,
   output logic signed [tcch_pkg::CW-1:0] x,
   output logic signed [tcch_pkg::CW-1:0] y,
   output logic signed [tcch_pkg::CW-1:0] z
);
   import tcch_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              vect_ff, vect_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [CW-1:0] xs, ys, at;
   logic              ccw;

   assign xs  = x_ff >>> iter_ff;
   assign ys  = y_ff >>> iter_ff;
   assign at  = atan_entry(int'(iter_ff));
   // vectoring drives y toward zero, rotation drives z toward zero
   assign ccw = vect_ff ? (y_ff[CW-1] || (y_ff == '0)) : !z_ff[CW-1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      vect_in = vect_ff;
      iter_in = iter_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         vect_in = cmd.vectoring;
         iter_in = '0;
         x_in    = x0;
         y_in    = y0;
         z_in    = z0;
      end else if (busy_ff) begin
         if (ccw) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + at;
         end
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      vect_ff <= vect_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign done = done_ff;
   assign x    = x_ff;
   assign y    = y_ff;
   assign z    = z_ff;

endmodule

// File: src/tcch_checker.sv
`timescale 1ns / 1ps
module tcch_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input tcch_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tcch_pkg::rsp_type rsp_data
);
   import tcch_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.heading < 16'd36000)
      else $error("heading out of range");

   a_meas_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.mode |=> req_stall)
      else $error("measurement request did not hold off the next");

   a_calib_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !req_data.mode && !rsp_valid |=> !rsp_valid)
      else $error("calibration request produced a response");

   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind tilt_compensated_compass_heading_top tcch_checker u_tcch_checker (.*);
